[hdl/ioc_pkg.sv]
`default_nettype none

package ioc_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned ABS_W   = 23;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned PROD_W  = ABS_W + RECIP_W;
  localparam int unsigned QN_W    = ABS_W + CNT_W;
  localparam int unsigned REM_W   = 9;
  localparam int unsigned DIV_W   = 4;

  localparam logic [1:0] OP_SAMPLE      = 2'd0;
  localparam logic [1:0] OP_GYRO_RECAL  = 2'd1;
  localparam logic [1:0] OP_ACCEL_RECAL = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [RAW_W-1:0] raw_accel_x;
    logic signed [RAW_W-1:0] raw_accel_y;
    logic signed [RAW_W-1:0] raw_accel_z;
    logic signed [RAW_W-1:0] raw_gyro_x;
    logic signed [RAW_W-1:0] raw_gyro_y;
    logic signed [RAW_W-1:0] raw_gyro_z;
  } in_word_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
    logic signed [RAW_W-1:0] rate_x;
    logic signed [RAW_W-1:0] rate_y;
    logic signed [RAW_W-1:0] rate_z;
    logic                    gyro_calibrated;
    logic                    accel_calibrated;
  } out_word_t;

endpackage

`default_nettype wire

[hdl/ioc_stream_if.sv]
`default_nettype none

interface ioc_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

[hdl/imu_offset_calibrator_core.sv]
// Six-axis zero-offset removal. Each sample word is registered, corrected by the stored
// accel and gyro offsets in one pass and presented on the output register, which is
// loaded from the input register; request words clear a calibrated flag and produce no
// output. One word is taken per cycle while the output drains and the divider is idle; a
// stalled output lets one more word into the input register and then holds the input. A
// sample word that ends a calibration run holds the input while the shared three-lane
// reciprocal-multiply divider turns the run sums into the new offsets. After reset both
// calibrations are pending and run on the incoming samples, gyro first per word.
`default_nettype none

module imu_offset_calibrator_core
  import ioc_pkg::*;
#(
  parameter int unsigned CAL_SAMPLES = 200
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ioc_stream_if.sink   in_i,
  ioc_stream_if.source out_o
);

  localparam int unsigned       DIV_SHIFT = 31;
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << DIV_SHIFT) / CAL_SAMPLES);
  localparam logic [CNT_W-1:0]  CAL_N     = CNT_W'(CAL_SAMPLES);

  logic                    in_vld_q;
  in_word_t                in_q;
  logic                    out_vld_q;
  out_word_t               out_q;
  out_word_t               out_d;

  logic signed [RAW_W-1:0] gyro_off_q [3];
  logic signed [RAW_W-1:0] gyro_off_d [3];
  logic signed [RAW_W-1:0] accel_off_q [3];
  logic signed [RAW_W-1:0] accel_off_d [3];
  logic signed [SUM_W-1:0] gyro_sum_q [3];
  logic signed [SUM_W-1:0] gyro_sum_d [3];
  logic signed [SUM_W-1:0] accel_sum_q [2];
  logic signed [SUM_W-1:0] accel_sum_d [2];
  logic [CNT_W-1:0]        gyro_cnt_q, gyro_cnt_d;
  logic [CNT_W-1:0]        accel_cnt_q, accel_cnt_d;
  logic                    gyro_done_q, gyro_done_d;
  logic                    accel_done_q, accel_done_d;

  logic signed [RAW_W-1:0] raw_acc [3];
  logic signed [RAW_W-1:0] raw_gyr [3];
  logic signed [RAW_W-1:0] acc [3];
  logic signed [RAW_W-1:0] gyr [3];
  logic                    is_sample;
  logic                    out_free;
  logic                    div_busy;
  logic                    fire;
  logic                    skip_accel;
  logic                    div_start;
  logic                    div_gyro_d;
  logic signed [SUM_W-1:0] div_load [3];

  logic [DIV_W-1:0]        div_vld_q;
  logic                    div_gyro_q;
  logic signed [SUM_W-1:0] div_sum_q [3];
  logic                    div_neg_q [3];
  logic [ABS_W-1:0]        div_abs_q [3];
  logic [PROD_W-1:0]       div_prod_q [3];
  logic [ABS_W-1:0]        div_quo_q [3];
  logic [REM_W-1:0]        div_rem_q [3];
  logic signed [SUM_W-1:0] div_mag [3];
  logic [PROD_W-1:0]       div_prod_d [3];
  logic [QN_W-1:0]         div_qn [3];
  logic [ABS_W-1:0]        div_rem_full [3];
  logic [ABS_W-1:0]        div_qc [3];
  logic [SUM_W-1:0]        div_res [3];

  assign raw_acc[0] = in_q.raw_accel_x;
  assign raw_acc[1] = in_q.raw_accel_y;
  assign raw_acc[2] = in_q.raw_accel_z;
  assign raw_gyr[0] = in_q.raw_gyro_x;
  assign raw_gyr[1] = in_q.raw_gyro_y;
  assign raw_gyr[2] = in_q.raw_gyro_z;

  assign is_sample  = (in_q.operation == OP_SAMPLE);
  assign out_free   = !out_vld_q || out_o.ready;
  assign div_busy   = |div_vld_q;
  assign fire       = in_vld_q && !div_busy && (out_free || !is_sample);
  assign in_i.ready = !in_vld_q || fire;

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = raw_acc[i] - accel_off_q[i];
      gyr[i] = raw_gyr[i] - gyro_off_q[i];
    end
  end

  // divider lanes: magnitude, reciprocal product, quotient estimate, correct and sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_mag[i]      = div_sum_q[i][SUM_W-1] ? -div_sum_q[i] : div_sum_q[i];
      div_prod_d[i]   = PROD_W'(div_abs_q[i]) * PROD_W'(RECIP);
      div_qn[i]       = QN_W'(div_prod_q[i][DIV_SHIFT +: ABS_W]) * QN_W'(CAL_N);
      div_rem_full[i] = div_abs_q[i] - div_qn[i][ABS_W-1:0];
      div_qc[i]       = div_quo_q[i] + ABS_W'(div_rem_q[i] >= REM_W'(CAL_N));
      div_res[i]      = div_neg_q[i] ? -SUM_W'(div_qc[i]) : SUM_W'(div_qc[i]);
    end
  end

  always_comb begin
    gyro_off_d   = gyro_off_q;
    accel_off_d  = accel_off_q;
    gyro_sum_d   = gyro_sum_q;
    accel_sum_d  = accel_sum_q;
    gyro_cnt_d   = gyro_cnt_q;
    accel_cnt_d  = accel_cnt_q;
    gyro_done_d  = gyro_done_q;
    accel_done_d = accel_done_q;
    skip_accel   = 1'b0;
    div_start    = 1'b0;
    div_gyro_d   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      div_load[i] = '0;
    end

    if (fire) begin
      unique case (in_q.operation)
        OP_SAMPLE: begin
          if (!gyro_done_q) begin
            if (gyro_cnt_q == '0) begin
              for (int i = 0; i < 3; i++) begin
                gyro_off_d[i] = '0;
                gyro_sum_d[i] = '0;
              end
              gyro_cnt_d = CNT_W'(1);
              skip_accel = 1'b1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                gyro_sum_d[i] = gyro_sum_q[i] + SUM_W'(gyr[i]);
              end
              if (gyro_cnt_q == CAL_N) begin
                div_start   = 1'b1;
                div_gyro_d  = 1'b1;
                div_load    = gyro_sum_d;
                gyro_cnt_d  = '0;
                gyro_done_d = 1'b1;
                skip_accel  = 1'b1;
              end else begin
                gyro_cnt_d = gyro_cnt_q + CNT_W'(1);
              end
            end
          end
          if (!skip_accel && !accel_done_q) begin
            if (accel_cnt_q == '0) begin
              for (int i = 0; i < 3; i++) begin
                accel_off_d[i] = '0;
              end
              accel_sum_d[0] = '0;
              accel_sum_d[1] = '0;
              accel_cnt_d    = CNT_W'(1);
            end else begin
              accel_sum_d[0] = accel_sum_q[0] + SUM_W'(acc[0]);
              accel_sum_d[1] = accel_sum_q[1] + SUM_W'(acc[1]);
              if (accel_cnt_q == CAL_N) begin
                div_start    = 1'b1;
                div_load[0]  = accel_sum_d[0];
                div_load[1]  = accel_sum_d[1];
                accel_cnt_d  = '0;
                accel_done_d = 1'b1;
              end else begin
                accel_cnt_d = accel_cnt_q + CNT_W'(1);
              end
            end
          end
        end
        OP_GYRO_RECAL:  gyro_done_d = 1'b0;
        OP_ACCEL_RECAL: accel_done_d = 1'b0;
        default: ;
      endcase
    end

    // load offsets from the divider
    if (div_vld_q[DIV_W-1]) begin
      for (int i = 0; i < 3; i++) begin
        if (div_gyro_q) begin
          gyro_off_d[i] = div_res[i][RAW_W-1:0];
        end else begin
          accel_off_d[i] = div_res[i][RAW_W-1:0];
        end
      end
    end
  end

  always_comb begin
    out_d.accel_x          = acc[0];
    out_d.accel_y          = acc[1];
    out_d.accel_z          = acc[2];
    out_d.rate_x           = gyr[0];
    out_d.rate_y           = gyr[1];
    out_d.rate_z           = gyr[2];
    out_d.gyro_calibrated  = gyro_done_d;
    out_d.accel_calibrated = accel_done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      div_vld_q    <= '0;
      gyro_cnt_q   <= '0;
      accel_cnt_q  <= '0;
      gyro_done_q  <= 1'b0;
      accel_done_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        gyro_off_q[i]  <= '0;
        accel_off_q[i] <= '0;
        gyro_sum_q[i]  <= '0;
      end
      accel_sum_q[0] <= '0;
      accel_sum_q[1] <= '0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (fire && is_sample) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      div_vld_q    <= {div_vld_q[DIV_W-2:0], div_start};
      gyro_cnt_q   <= gyro_cnt_d;
      accel_cnt_q  <= accel_cnt_d;
      gyro_done_q  <= gyro_done_d;
      accel_done_q <= accel_done_d;
      gyro_off_q   <= gyro_off_d;
      accel_off_q  <= accel_off_d;
      gyro_sum_q   <= gyro_sum_d;
      accel_sum_q  <= accel_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (fire && is_sample) begin
      out_q <= out_d;
    end
    if (div_start) begin
      div_gyro_q <= div_gyro_d;
      div_sum_q  <= div_load;
    end
    for (int i = 0; i < 3; i++) begin
      if (div_vld_q[0]) begin
        div_neg_q[i] <= div_sum_q[i][SUM_W-1];
        div_abs_q[i] <= div_mag[i][ABS_W-1:0];
      end
      if (div_vld_q[1]) begin
        div_prod_q[i] <= div_prod_d[i];
      end
      if (div_vld_q[2]) begin
        div_quo_q[i] <= div_prod_q[i][DIV_SHIFT +: ABS_W];
        div_rem_q[i] <= div_rem_full[i][REM_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ioc_checker.sv]
`default_nettype none

module ioc_checker
  import ioc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  logic last_gyro_q;
  logic last_accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_gyro_q  <= 1'b0;
      last_accel_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      last_gyro_q  <= out_data_i.gyro_calibrated;
      last_accel_q <= out_data_i.accel_calibrated;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_ready_i && !out_valid_i)
    else $error("block not idle after reset");

  a_one_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(!last_gyro_q && out_data_i.gyro_calibrated &&
                      !last_accel_q && out_data_i.accel_calibrated))
    else $error("gyro and accel calibration finished on the same word");

endmodule

bind imu_offset_calibrator_core ioc_checker u_ioc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
